// File: rtl/core/tdpt_pkg.sv
// Shared constants and controller/datapath handshake types for the
// trial division prime test core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

   localparam int NUMBER_WIDTH_DEFAULT = 32;
   localparam int FIRST_DIVISOR        = 3;
   localparam int DIVISOR_STEP         = 2;
   localparam int SMALLEST_PRIME       = 2;

   typedef struct packed {
      logic load;
      logic start_div;
      logic step_div;
      logic advance;
      logic emit;
      logic verdict;
   } cmd_type;

   typedef struct packed {
      logic even;
      logic is_two;
      logic below_three;
      logic bound_exceeded;
      logic div_last;
      logic rem_zero;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/tdpt_if.sv
// Valid/ready channel interfaces for the request and response words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tdpt_req_if #(
   parameter int NUMBER_WIDTH = 32
);
   logic                    valid;
   logic                    ready;
   logic [NUMBER_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink (input valid, input candidate, output ready);
endinterface

interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tdpt_ctrl.sv
// Sequencer for the prime test: classifies the word, loops over divisors
// and hands the verdict to the response register. Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire                  rsp_ready,
   output logic                 rsp_valid,
   input  tdpt_pkg::status_type status,
   output tdpt_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CLASSIFY = 3'd1;
   localparam logic [2:0] S_BOUND    = 3'd2;
   localparam logic [2:0] S_DIVIDE   = 3'd3;
   localparam logic [2:0] S_TEST     = 3'd4;
   localparam logic [2:0] S_FINISH   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       verdict_ff;
   logic       verdict_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            if (status.even) begin
               verdict_in = status.is_two;
               state_in   = S_FINISH;
            end else if (status.below_three) begin
               verdict_in = 1'b0;
               state_in   = S_FINISH;
            end else begin
               state_in = S_BOUND;
            end
         end
         S_BOUND: begin
            if (status.bound_exceeded) begin
               verdict_in = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.step_div = 1'b1;
            if (status.div_last) begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (status.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_BOUND;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.verdict = verdict_ff;
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         verdict_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         verdict_ff   <= verdict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/tdpt_dp.sv
// Datapath: candidate, divisor, running divisor square, bit-serial
// restoring remainder unit and response register. Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_dp #(
   parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  wire                     clock,
   input  wire [NUMBER_WIDTH-1:0]  candidate,
   input  tdpt_pkg::cmd_type       cmd,
   output tdpt_pkg::status_type    status,
   output logic                    is_prime
);

   localparam int SqWidth  = NUMBER_WIDTH + 2;
   localparam int CntWidth = $clog2(NUMBER_WIDTH + 1);

   logic [NUMBER_WIDTH-1:0] n_ff;
   logic [NUMBER_WIDTH-1:0] n_in;
   logic [NUMBER_WIDTH-1:0] d_ff;
   logic [NUMBER_WIDTH-1:0] d_in;
   logic [SqWidth-1:0]      sq_ff;
   logic [SqWidth-1:0]      sq_in;
   logic [NUMBER_WIDTH-1:0] rem_ff;
   logic [NUMBER_WIDTH-1:0] rem_in;
   logic [NUMBER_WIDTH-1:0] sh_ff;
   logic [NUMBER_WIDTH-1:0] sh_in;
   logic [CntWidth-1:0]     cnt_ff;
   logic [CntWidth-1:0]     cnt_in;
   logic                    is_prime_ff;
   logic                    is_prime_in;
   logic [NUMBER_WIDTH:0]   trial;
   logic [NUMBER_WIDTH:0]   d_ext;

   assign trial = {rem_ff, sh_ff[NUMBER_WIDTH-1]};
   assign d_ext = {1'b0, d_ff};

   always_comb begin
      n_in        = n_ff;
      d_in        = d_ff;
      sq_in       = sq_ff;
      rem_in      = rem_ff;
      sh_in       = sh_ff;
      cnt_in      = cnt_ff;
      is_prime_in = is_prime_ff;
      if (cmd.load) begin
         n_in  = candidate;
         d_in  = NUMBER_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
         sq_in = SqWidth'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
      end
      if (cmd.start_div) begin
         rem_in = '0;
         sh_in  = n_ff;
         cnt_in = CntWidth'(NUMBER_WIDTH);
      end
      if (cmd.step_div) begin
         if (trial >= d_ext) begin
            rem_in = NUMBER_WIDTH'(trial - d_ext);
         end else begin
            rem_in = trial[NUMBER_WIDTH-1:0];
         end
         sh_in  = {sh_ff[NUMBER_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CntWidth'(1);
      end
      if (cmd.advance) begin
         d_in  = d_ff + NUMBER_WIDTH'(tdpt_pkg::DIVISOR_STEP);
         sq_in = sq_ff + {d_ff, 2'b00} + SqWidth'(4);
      end
      if (cmd.emit) begin
         is_prime_in = cmd.verdict;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      sh_ff       <= sh_in;
      cnt_ff      <= cnt_in;
      is_prime_ff <= is_prime_in;
   end

   assign status.even           = ~n_ff[0];
   assign status.is_two         = (n_ff == NUMBER_WIDTH'(tdpt_pkg::SMALLEST_PRIME));
   assign status.below_three    = (n_ff < NUMBER_WIDTH'(tdpt_pkg::FIRST_DIVISOR));
   assign status.bound_exceeded = (sq_ff > {2'b00, n_ff});
   assign status.div_last       = (cnt_ff == CntWidth'(1));
   assign status.rem_zero       = (rem_ff == '0);
   assign is_prime              = is_prime_ff;

endmodule

`default_nettype wire

// File: rtl/core/trial_division_prime_test_core.sv
// Trial division prime test: one word in, one prime flag out.
// Even words and words below three are decided in the classify step, without trial division.
// Other odd words repeat a bound check, a bit-serial remainder and a zero test for each odd
// divisor tried, plus one final bound check for a prime; up to about 2^(NUMBER_WIDTH/2 - 1)
// odd divisors are tried. One word in flight; reset clears control.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test_core #(
   parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   tdpt_req_if.sink   req_ch,
   tdpt_rsp_if.source rsp_ch
);

   tdpt_pkg::cmd_type    cmd;
   tdpt_pkg::status_type status;
   logic                 req_ready;
   logic                 rsp_valid;
   logic                 is_prime;

   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   tdpt_dp #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_dp (
      .clock     (clock),
      .candidate (req_ch.candidate),
      .cmd       (cmd),
      .status    (status),
      .is_prime  (is_prime)
   );

   assign req_ch.ready    = req_ready;
   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.is_prime = is_prime;

endmodule

`default_nettype wire

// File: tb/sv/trial_division_prime_test_core_tb.sv
// Self-checking testbench for trial_division_prime_test_core: drives candidate words,
// predicts each prime flag by trial division and compares it with the response word.
// Depends on tdpt_pkg, the tdpt_req_if/tdpt_rsp_if interfaces and the core RTL.
`timescale 1ns / 1ps

module trial_division_prime_test_core_tb;

   localparam int NW            = tdpt_pkg::NUMBER_WIDTH_DEFAULT;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 7;
   localparam int MAX_BURST     = 13;
   localparam int TAIL_WORDS    = 15;
   localparam int DRAIN_CYCLES  = 60;
   localparam int RANDOM_WORDS  = 76;
   localparam int LARGE_TRIALS  = 300;
   localparam int REPORT_LIMIT  = 10;

   logic clock;
   logic reset;

   tdpt_req_if #(.NUMBER_WIDTH(NW)) req_ch ();
   tdpt_rsp_if rsp_ch ();

   trial_division_prime_test_core #(.NUMBER_WIDTH(NW)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [NW-1:0]   pending_candidates[$];
   logic            expected_verdicts[$];
   int unsigned     words_shown;
   int unsigned     words_taken;
   int unsigned     total_words;
   int unsigned     fault_count;
   longint unsigned cycle_count;
   longint unsigned cycle_limit;
   int unsigned     send_idle_left;
   int unsigned     send_calm_left;
   int unsigned     recv_stall_left;
   int unsigned     recv_calm_left;

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   function automatic logic prime_verdict(input logic [NW-1:0] n,
                                          output longint unsigned divisors_tried);
      logic [NW-1:0] d;
      logic          verdict;
      divisors_tried = 0;
      if (!n[0]) begin
         verdict = (n == NW'(tdpt_pkg::SMALLEST_PRIME));
      end else if (n < NW'(tdpt_pkg::FIRST_DIVISOR)) begin
         verdict = 1'b0;
      end else begin
         verdict = 1'b1;
         d = NW'(tdpt_pkg::FIRST_DIVISOR);
         while (verdict && d <= n / d) begin
            divisors_tried++;
            if (n % d == 0) verdict = 1'b0;
            d += NW'(tdpt_pkg::DIVISOR_STEP);
         end
      end
      return verdict;
   endfunction

   task automatic queue_candidate(input logic [NW-1:0] n);
      longint unsigned tried;
      void'(prime_verdict(n, tried));
      pending_candidates.push_back(n);
      cycle_limit += 4 * (3 + (tried + 1) * (NW + 2) + 2 * MAX_BURST + 4);
   endtask

   // drive request and response sides on the falling edge
   always @(negedge clock) begin
      logic next_valid;
      logic next_ready;
      if (reset !== 1'b0) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         next_valid = req_ch.valid && (words_taken != words_shown);
         if (!next_valid) begin
            if (send_idle_left > 0) begin
               send_idle_left--;
            end else if (send_calm_left == 0 && pending_candidates.size() > TAIL_WORDS &&
                         $urandom_range(0, 3) == 0) begin
               send_idle_left = $urandom_range(0, MAX_BURST - 1);
               send_calm_left = $urandom_range(0, 40);
            end else begin
               if (send_calm_left > 0) send_calm_left--;
               if (pending_candidates.size() > 0) begin
                  req_ch.candidate <= pending_candidates.pop_front();
                  words_shown++;
                  next_valid = 1'b1;
               end
            end
         end
         req_ch.valid <= next_valid;

         next_ready = 1'b1;
         if (recv_stall_left > 0) begin
            recv_stall_left--;
            next_ready = 1'b0;
         end else if (recv_calm_left == 0 && pending_candidates.size() > TAIL_WORDS &&
                      $urandom_range(0, 3) == 0) begin
            recv_stall_left = $urandom_range(0, MAX_BURST - 1);
            recv_calm_left  = $urandom_range(0, 40);
            next_ready = 1'b0;
         end else if (recv_calm_left > 0) begin
            recv_calm_left--;
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // sample handshakes on the rising edge
   always @(posedge clock) begin
      longint unsigned tried;
      logic            want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            expected_verdicts.push_back(prime_verdict(req_ch.candidate, tried));
            words_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_verdicts.size() == 0) begin
               if (fault_count < REPORT_LIMIT)
                  $display("unexpected response word: is_prime=%0b", rsp_ch.is_prime);
               fault_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_ch.is_prime !== want) begin
                  if (fault_count < REPORT_LIMIT)
                     $display("is_prime mismatch: expected %0b, got %0b", want,
                              rsp_ch.is_prime);
                  fault_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("FAIL trial_division_prime_test_core");
         $finish;
      end
   end

   initial begin
      int unsigned     pick;
      int unsigned     root;
      logic [NW-1:0]   n;
      longint unsigned tried;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.candidate = '0;
      rsp_ch.ready     = 1'b0;
      words_shown      = 0;
      words_taken      = 0;
      fault_count      = 0;
      cycle_count      = 0;
      cycle_limit      = RESET_CYCLES + DRAIN_CYCLES + 10000;
      send_idle_left   = 0;
      send_calm_left   = 0;
      recv_stall_left  = 0;
      recv_calm_left   = 0;

      queue_candidate(32'd0);
      queue_candidate(32'd1);
      queue_candidate(32'd2);
      queue_candidate(32'd3);
      queue_candidate(32'd4);
      queue_candidate(32'd5);
      queue_candidate(32'd9);
      queue_candidate(32'd15);
      queue_candidate(32'd25);
      queue_candidate(32'd49);
      queue_candidate(32'd97);
      queue_candidate(32'd121);
      queue_candidate(32'd169);
      queue_candidate(32'd65535);
      queue_candidate(32'd65537);
      queue_candidate(32'd1042441);
      queue_candidate(32'h5555_5555);
      queue_candidate(32'hAAAA_AAAA);
      queue_candidate(32'h8000_0000);
      queue_candidate(32'hFFFF_FFFE);
      queue_candidate(32'hFFFF_FFFF);
      queue_candidate(32'd4294967293);
      queue_candidate(32'd4293001441);
      queue_candidate(32'd4294967291);

      repeat (RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 4) begin
            n = $urandom_range(0, 4095);
         end else if (pick <= 6) begin
            n = $urandom_range(0, 32'h000F_FFFF);
         end else if (pick == 7) begin
            root = $urandom_range(1, 500) | 1;
            n = root * root;
         end else begin
            n = $urandom;
            void'(prime_verdict(n, tried));
            while (tried > LARGE_TRIALS) begin
               n = $urandom;
               void'(prime_verdict(n, tried));
            end
         end
         queue_candidate(n);
      end
      total_words = pending_candidates.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_taken < total_words || expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("PASS trial_division_prime_test_core");
      else
         $display("FAIL trial_division_prime_test_core");
      $finish;
   end

endmodule
